// ----- design/lrk4_pkg.sv -----
package lrk4_pkg;

  typedef logic signed [31:0] q_t;

  localparam logic signed [31:0] QMAX = 32'sh7FFFFFFF;
  localparam logic signed [31:0] QMIN = 32'sh80000000;
  localparam logic signed [31:0] ESC_LIMIT = 32'sd65536000;

  localparam logic [2:0] REG_SIGMA = 3'd0;
  localparam logic [2:0] REG_RHO   = 3'd1;
  localparam logic [2:0] REG_BETA  = 3'd2;
  localparam logic [2:0] REG_DT    = 3'd3;
  localparam logic [2:0] REG_CX    = 3'd4;
  localparam logic [2:0] REG_SX    = 3'd5;
  localparam logic [2:0] REG_CY    = 3'd6;
  localparam logic [2:0] REG_SY    = 3'd7;

  // clamp a wide signed value to q15.16
  function automatic q_t sat64(input logic signed [63:0] v);
    if (v > 64'(QMAX)) return QMAX;
    else if (v < 64'(QMIN)) return QMIN;
    else return v[31:0];
  endfunction

  // product floor-shifted by 16 and saturated
  function automatic q_t qmul(input q_t a, input q_t b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b);
    return sat64(p >>> 16);
  endfunction

  function automatic q_t qadd(input q_t a, input q_t b);
    return sat64(64'(a) + 64'(b));
  endfunction

  function automatic q_t qsub(input q_t a, input q_t b);
    return sat64(64'(a) - 64'(b));
  endfunction

  // sixth of a 17-bit step by reciprocal: floor(v*43691 >> 18) exact for v < 2^17
  function automatic logic [14:0] sixth_of(input logic [16:0] v);
    logic [33:0] m;
    m = 34'(v) * 34'd43691;
    return m[32:18];
  endfunction

endpackage

// ----- design/lorenz_rk4_step.sv -----
// lorenz_rk4_step: one rk4 step of the lorenz system per point, q15.16
// throughput: one point per cycle; a stall freezes the whole pipeline
// reset: rst_n synchronous active low, clears valid bits and loads default
// coefficients; pipeline payload registers are not reset
module lorenz_rk4_step (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  lrk4_pkg::q_t in_pos_x,
  input  lrk4_pkg::q_t in_pos_y,
  input  lrk4_pkg::q_t in_pos_z,
  input  logic [15:0] in_rand_x,
  input  logic [15:0] in_rand_y,
  input  logic [15:0] in_rand_z,
  output logic        out_valid,
  input  logic        out_stall,
  output lrk4_pkg::q_t out_next_x,
  output lrk4_pkg::q_t out_next_y,
  output lrk4_pkg::q_t out_next_z,
  output lrk4_pkg::q_t out_incr_x,
  output lrk4_pkg::q_t out_incr_y,
  output lrk4_pkg::q_t out_incr_z,
  output logic        out_escaped,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import lrk4_pkg::*;

  localparam int NST = 22;

  // configuration registers
  q_t sigma_r, rho_r, beta_r, cx_r, sx_r, cy_r, sy_r;
  logic [16:0] dt_r;
  logic [15:0] half_r;
  logic [14:0] sixth_r;
  logic [2:0] ridx;
  logic wr_en;

  assign pready = 1'b1;
  assign ridx = paddr[4:2];
  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sigma_r <= 32'sd655360;
      rho_r   <= 32'sd1835008;
      beta_r  <= -32'sd174763;
      dt_r    <= 17'd655;
      cx_r    <= '0;
      sx_r    <= 32'sd655360;
      cy_r    <= '0;
      sy_r    <= 32'sd655360;
    end else if (wr_en) begin
      unique case (ridx)
        REG_SIGMA: sigma_r <= pwdata;
        REG_RHO:   rho_r   <= pwdata;
        REG_BETA:  beta_r  <= pwdata;
        REG_DT:    dt_r    <= pwdata[16:0];
        REG_CX:    cx_r    <= pwdata;
        REG_SX:    sx_r    <= pwdata;
        REG_CY:    cy_r    <= pwdata;
        REG_SY:    sy_r    <= pwdata;
        default: ;
      endcase
    end
  end

  // derived step fractions; user must change dt only while idle (not enforced)
  always_ff @(posedge clk) begin
    half_r  <= dt_r[16:1];
    sixth_r <= sixth_of(dt_r);
  end

  always_comb begin
    unique case (ridx)
      REG_SIGMA: prdata = sigma_r;
      REG_RHO:   prdata = rho_r;
      REG_BETA:  prdata = beta_r;
      REG_DT:    prdata = {15'd0, dt_r};
      REG_CX:    prdata = cx_r;
      REG_SX:    prdata = sx_r;
      REG_CY:    prdata = cy_r;
      REG_SY:    prdata = sy_r;
      default:   prdata = '0;
    endcase
  end

  // pipeline: the whole chain moves when the output is not stalled or holds no valid result
  logic adv;
  assign adv = !out_stall || !out_valid;
  assign in_stall = !adv;

  logic [NST-1:0] v_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else if (adv) v_r <= {v_r[NST-2:0], in_valid};
  end
  assign out_valid = v_r[NST-1];

  // per-stage carried point and randoms
  q_t px_r [NST], py_r [NST], pz_r [NST];
  logic [15:0] rx_r [NST], ry_r [NST], rz_r [NST];
  // current evaluation point t, k sums
  q_t tx_r [NST], ty_r [NST], tz_r [NST];
  q_t ax_r [NST], ay_r [NST], az_r [NST];   // scratch a
  q_t bx_r [NST], by_r [NST], bz_r [NST];   // scratch b
  logic signed [35:0] sx_acc_r [NST], sy_acc_r [NST], sz_acc_r [NST];

  // stage schedule per derivative evaluation:
  //  e0: a = y-x, b = rho-z
  //  e1: ay = sigma*a, by = b*x, cx1 = beta*z, cy1 = x*y, kept in separate regs
  //  simpler: e0 diffs, e1 products, e2 final adds (k), e3 k*h and sum
  //  e4 advance add
  q_t cx1_r [NST], cy1_r [NST];  // beta*z and x*y partials

  // next values of every stage register
  q_t px_nxt [NST], py_nxt [NST], pz_nxt [NST];
  logic [15:0] rx_nxt [NST], ry_nxt [NST], rz_nxt [NST];
  q_t tx_nxt [NST], ty_nxt [NST], tz_nxt [NST];
  q_t ax_nxt [NST], ay_nxt [NST], az_nxt [NST];
  q_t bx_nxt [NST], by_nxt [NST], bz_nxt [NST];
  logic signed [35:0] sx_acc_nxt [NST], sy_acc_nxt [NST], sz_acc_nxt [NST];
  q_t cx1_nxt [NST], cy1_nxt [NST];

  function automatic int st(input int e, input int k);
    return 5 * e + k;
  endfunction

  always_comb begin
    // stage 0: capture input
    px_nxt[0] = in_pos_x; py_nxt[0] = in_pos_y; pz_nxt[0] = in_pos_z;
    rx_nxt[0] = in_rand_x; ry_nxt[0] = in_rand_y; rz_nxt[0] = in_rand_z;
    tx_nxt[0] = in_pos_x; ty_nxt[0] = in_pos_y; tz_nxt[0] = in_pos_z;
    ax_nxt[0] = '0; ay_nxt[0] = '0; az_nxt[0] = '0;
    bx_nxt[0] = '0; by_nxt[0] = '0; bz_nxt[0] = '0;
    cx1_nxt[0] = '0; cy1_nxt[0] = '0;
    sx_acc_nxt[0] = '0; sy_acc_nxt[0] = '0; sz_acc_nxt[0] = '0;
    for (int s = 1; s < NST; s++) begin
      px_nxt[s] = px_r[s-1]; py_nxt[s] = py_r[s-1]; pz_nxt[s] = pz_r[s-1];
      rx_nxt[s] = rx_r[s-1]; ry_nxt[s] = ry_r[s-1]; rz_nxt[s] = rz_r[s-1];
      tx_nxt[s] = tx_r[s-1]; ty_nxt[s] = ty_r[s-1]; tz_nxt[s] = tz_r[s-1];
      ax_nxt[s] = ax_r[s-1]; ay_nxt[s] = ay_r[s-1]; az_nxt[s] = az_r[s-1];
      bx_nxt[s] = bx_r[s-1]; by_nxt[s] = by_r[s-1]; bz_nxt[s] = bz_r[s-1];
      cx1_nxt[s] = cx1_r[s-1]; cy1_nxt[s] = cy1_r[s-1];
      sx_acc_nxt[s] = sx_acc_r[s-1]; sy_acc_nxt[s] = sy_acc_r[s-1];
      sz_acc_nxt[s] = sz_acc_r[s-1];
    end
    for (int e = 0; e < 4; e++) begin
      // diffs
      ax_nxt[st(e,1)] = qsub(ty_r[st(e,0)], tx_r[st(e,0)]);
      bx_nxt[st(e,1)] = qsub(rho_r, tz_r[st(e,0)]);
      // products
      ay_nxt[st(e,2)] = qmul(sigma_r, ax_r[st(e,1)]);
      by_nxt[st(e,2)] = qmul(bx_r[st(e,1)], tx_r[st(e,1)]);
      cx1_nxt[st(e,2)] = qmul(beta_r, tz_r[st(e,1)]);
      cy1_nxt[st(e,2)] = qmul(tx_r[st(e,1)], ty_r[st(e,1)]);
      // k values in az,bz,cx1 slots: kx=ay, ky=by-y, kz=c1+c2
      az_nxt[st(e,3)] = ay_r[st(e,2)];
      bz_nxt[st(e,3)] = qsub(by_r[st(e,2)], ty_r[st(e,2)]);
      cx1_nxt[st(e,3)] = qadd(cx1_r[st(e,2)], cy1_r[st(e,2)]);
      // weighted accumulate, and k times half or full step for the next evaluation point
      if (e == 0 || e == 3) begin
        sx_acc_nxt[st(e,4)] = sx_acc_r[st(e,3)] + 36'(az_r[st(e,3)]);
        sy_acc_nxt[st(e,4)] = sy_acc_r[st(e,3)] + 36'(bz_r[st(e,3)]);
        sz_acc_nxt[st(e,4)] = sz_acc_r[st(e,3)] + 36'(cx1_r[st(e,3)]);
      end else begin
        sx_acc_nxt[st(e,4)] = sx_acc_r[st(e,3)] + (36'(az_r[st(e,3)]) <<< 1);
        sy_acc_nxt[st(e,4)] = sy_acc_r[st(e,3)] + (36'(bz_r[st(e,3)]) <<< 1);
        sz_acc_nxt[st(e,4)] = sz_acc_r[st(e,3)] + (36'(cx1_r[st(e,3)]) <<< 1);
      end
      if (e < 3) begin
        ax_nxt[st(e,4)] = qmul(az_r[st(e,3)], (e == 2) ? q_t'(dt_r) : q_t'(half_r));
        ay_nxt[st(e,4)] = qmul(bz_r[st(e,3)], (e == 2) ? q_t'(dt_r) : q_t'(half_r));
        az_nxt[st(e,4)] = qmul(cx1_r[st(e,3)], (e == 2) ? q_t'(dt_r) : q_t'(half_r));
        // advance to next evaluation point
        tx_nxt[st(e+1,0)] = qadd(px_r[st(e,4)], ax_r[st(e,4)]);
        ty_nxt[st(e+1,0)] = qadd(py_r[st(e,4)], ay_r[st(e,4)]);
        tz_nxt[st(e+1,0)] = qadd(pz_r[st(e,4)], az_r[st(e,4)]);
      end
    end
    // stage 20: increment = floor(s*sixth/65536) saturated (36x15 bit product), and reseed points
    ax_nxt[20] = sat64((64'(sx_acc_r[19]) * $signed(64'(sixth_r))) >>> 16);
    ay_nxt[20] = sat64((64'(sy_acc_r[19]) * $signed(64'(sixth_r))) >>> 16);
    az_nxt[20] = sat64((64'(sz_acc_r[19]) * $signed(64'(sixth_r))) >>> 16);
    bx_nxt[20] = qadd(cx_r, sat64((64'(sx_r) * $signed(64'(rx_r[19]))) >>> 16));
    by_nxt[20] = qadd(cy_r, sat64((64'(sy_r) * $signed(64'(ry_r[19]))) >>> 16));
    bz_nxt[20] = qadd(cy_r, sat64((64'(sy_r) * $signed(64'(rz_r[19]))) >>> 16));
    // stage 21: new point and escape test
    tx_nxt[21] = qadd(px_r[20], ax_r[20]);
    ty_nxt[21] = qadd(py_r[20], ay_r[20]);
    tz_nxt[21] = qadd(pz_r[20], az_r[20]);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      px_r <= px_nxt; py_r <= py_nxt; pz_r <= pz_nxt;
      rx_r <= rx_nxt; ry_r <= ry_nxt; rz_r <= rz_nxt;
      tx_r <= tx_nxt; ty_r <= ty_nxt; tz_r <= tz_nxt;
      ax_r <= ax_nxt; ay_r <= ay_nxt; az_r <= az_nxt;
      bx_r <= bx_nxt; by_r <= by_nxt; bz_r <= bz_nxt;
      cx1_r <= cx1_nxt; cy1_r <= cy1_nxt;
      sx_acc_r <= sx_acc_nxt; sy_acc_r <= sy_acc_nxt; sz_acc_r <= sz_acc_nxt;
    end
  end

  logic ex, ey, ez;
  assign ex = (tx_r[21] > ESC_LIMIT) || (tx_r[21] < -ESC_LIMIT);
  assign ey = (ty_r[21] > ESC_LIMIT) || (ty_r[21] < -ESC_LIMIT);
  assign ez = (tz_r[21] > ESC_LIMIT) || (tz_r[21] < -ESC_LIMIT);

  assign out_next_x = ex ? bx_r[21] : tx_r[21];
  assign out_next_y = ey ? by_r[21] : ty_r[21];
  assign out_next_z = ez ? bz_r[21] : tz_r[21];
  assign out_incr_x = ax_r[21];
  assign out_incr_y = ay_r[21];
  assign out_incr_z = az_r[21];
  assign out_escaped = ex || ey || ez;

  // a stalled result holds its slot
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_next_x) && $stable(out_incr_z))
    else $error("stalled result changed");
  // input stall only arises from an output stall
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output stall");
  // escape flag agrees with the reseed choice
  a_esc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_escaped |-> out_next_x == tx_r[21])
    else $error("escape flag mismatch");

endmodule
